@@ design/mlcd_pkg.sv @@
// Package for the MESI/LRU cache directory: operation codes, line states,
// directory geometry, the result word type and the request queue entry. No dependencies.
package mlcd_pkg;

  localparam int TAG_W = 12;
  localparam int OP_W  = 4;

  // Directory geometry: sets of the line memory and ways per set.
  localparam int SETS  = 16384;
  localparam int WAYS  = 16;
  localparam int SET_W = $clog2(SETS);
  localparam int AGE_W = $clog2(WAYS);

  // Operation codes.
  localparam logic [3:0] OP_READ   = 4'd0;
  localparam logic [3:0] OP_WRITE  = 4'd1;
  localparam logic [3:0] OP_FETCH  = 4'd2;
  localparam logic [3:0] OP_SN_INV = 4'd3;
  localparam logic [3:0] OP_SN_RD  = 4'd4;
  localparam logic [3:0] OP_SN_WR  = 4'd5;
  localparam logic [3:0] OP_SN_OWN = 4'd6;
  localparam logic [3:0] OP_CLEAR  = 4'd8;

  // Line states.
  localparam logic [1:0] ST_M = 2'd0;
  localparam logic [1:0] ST_E = 2'd1;
  localparam logic [1:0] ST_S = 2'd2;
  localparam logic [1:0] ST_I = 2'd3;

  // Outcome codes.
  localparam logic [1:0] OC_NONE = 2'd0;
  localparam logic [1:0] OC_HIT  = 2'd1;
  localparam logic [1:0] OC_MISS = 2'd2;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic [3:0]       op;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_bits;
    logic             rd;
    logic             wr;
  } mlcd_req_t;

  // One result word.
  typedef struct packed {
    logic       counts_write;
    logic       counts_read;
    logic [1:0] new_state;
    logic [3:0] way_used;
    logic       hit_modified;
    logic [1:0] outcome;
  } mlcd_res_t;

endpackage

@@ design/mlcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mlcd_front.sv @@
// Front part: accepts access words, classifies them and pushes them into a
// two-entry request queue. Depends on mlcd_pkg.
module mlcd_front import mlcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic [35:0] in_tdata,
  output logic      q_valid,
  input  logic      q_pop,
  output mlcd_req_t q_head
);

  mlcd_req_t   ent_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rp_r, wp_r;
  mlcd_req_t   req;
  logic [3:0]  op;
  logic        push;

  // Classify the incoming word.
  always_comb begin
    op           = in_tdata[3:0];
    req.op       = op;
    req.tag      = in_tdata[35:24];
    req.set_bits = in_tdata[23:10];
    req.rd       = op inside {OP_READ, OP_FETCH, OP_SN_RD, OP_SN_OWN};
    req.wr       = op inside {OP_WRITE, OP_SN_WR};
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = ent_r[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, q_pop};

  // Queue pointers and storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rp_r  <= 1'b0;
      wp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
    if (push) ent_r[wp_r] <= req;
  end

endmodule

@@ design/mlcd_back.sv @@
// Back part: reads a set from the line memory, resolves the MESI and LRU
// update, writes the set back and produces the result. Depends on mlcd_pkg
// and mlcd_ram.
module mlcd_back import mlcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  mlcd_req_t q_head,
  output logic      res_valid,
  input  logic      res_ready,
  output mlcd_res_t res_data
);

  localparam int LINE_W = TAG_W + 2 + AGE_W;
  localparam int ROW_W = WAYS * LINE_W;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_READ, S_EXEC} st_t;

  st_t              st_r;
  logic [SET_W-1:0] clr_r;
  mlcd_req_t        req_r;
  logic             res_valid_r;
  mlcd_res_t        res_r;
  logic [SET_W-1:0] set_idx;
  logic [ROW_W-1:0] row_rd, row_wr, row_rst;
  logic             we;
  logic [SET_W-1:0] waddr;
  logic [ROW_W-1:0] wdata;

  // Per-way fields of the row that was read.
  logic [TAG_W-1:0] tg [WAYS];
  logic [1:0]       sv [WAYS];
  logic [AGE_W-1:0] ag [WAYS];
  logic [TAG_W-1:0] ntg [WAYS];
  logic [1:0]       nsv [WAYS];
  logic [AGE_W-1:0] nag [WAYS];

  logic             match, victim_found, valid, touch_en, change;
  logic [AGE_W-1:0] mway, vway, way, old_age;
  logic [1:0]       nst, cur_st;
  mlcd_res_t        res;

  assign set_idx = req_r.set_bits;

  // Row image of a freshly reset set.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_rst[w*LINE_W +: LINE_W] = {{TAG_W{1'b0}}, ST_I, AGE_W'(w)};
    end
  end

  mlcd_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(set_idx), .rdata(row_rd)
  );

  // Tag lookup and victim search over the set.
  always_comb begin
    match = 1'b0;
    mway = '0;
    victim_found = 1'b0;
    vway = '0;
    for (int w = 0; w < WAYS; w++) begin
      {tg[w], sv[w], ag[w]} = row_rd[w*LINE_W +: LINE_W];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tg[w] == req_r.tag) begin
        match = 1'b1;
        mway = AGE_W'(w);
      end
      if (ag[w] == '0) begin
        victim_found = 1'b1;
        vway = AGE_W'(w);
      end
    end
  end

  // MESI decision for the access.
  always_comb begin
    res = '0;
    res.new_state = ST_I;
    res.counts_read = req_r.rd;
    res.counts_write = req_r.wr;
    way = match ? mway : (victim_found ? vway : '0);
    cur_st = sv[way];
    valid = match && (cur_st != ST_I);
    touch_en = 1'b0;
    change = 1'b0;
    nst = cur_st;
    case (req_r.op)
      OP_READ, OP_FETCH, OP_WRITE: begin
        change = 1'b1;
        touch_en = 1'b1;
        res.outcome = valid ? OC_HIT : OC_MISS;
        if (req_r.op == OP_WRITE) nst = ST_M;
        else if (!valid) nst = ST_E;
        res.way_used = way;
        res.new_state = nst;
      end
      OP_SN_INV, OP_SN_RD, OP_SN_WR, OP_SN_OWN: begin
        if (match) begin
          res.way_used = way;
          if (valid) begin
            change = 1'b1;
            res.outcome = OC_HIT;
            res.hit_modified = (req_r.op == OP_SN_RD || req_r.op == OP_SN_OWN)
                               && cur_st == ST_M;
            nst = (req_r.op == OP_SN_RD) ? ST_S : ST_I;
            touch_en = (req_r.op != OP_SN_RD);
          end else begin
            res.outcome = OC_MISS;
          end
          res.new_state = nst;
        end else if (req_r.op == OP_SN_INV || req_r.op == OP_SN_WR) begin
          res.outcome = OC_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  // New row contents with the LRU update.
  always_comb begin
    old_age = ag[way];
    for (int w = 0; w < WAYS; w++) begin
      ntg[w] = tg[w];
      nsv[w] = sv[w];
      nag[w] = ag[w];
      if (touch_en && old_age != AGE_W'(WAYS - 1) && ag[w] > old_age) begin
        nag[w] = ag[w] - AGE_W'(1);
      end
      if (AGE_W'(w) == way) begin
        if (touch_en && old_age != AGE_W'(WAYS - 1)) nag[w] = AGE_W'(WAYS - 1);
        nsv[w] = nst;
        if (!match) ntg[w] = req_r.tag;
      end
      row_wr[w*LINE_W +: LINE_W] = {ntg[w], nsv[w], nag[w]};
    end
  end

  // Memory write selection: clearing sweep or write-back.
  always_comb begin
    we = 1'b0;
    waddr = set_idx;
    wdata = row_wr;
    if (st_r == S_CLR) begin
      we = 1'b1;
      waddr = clr_r;
      wdata = row_rst;
    end else if (st_r == S_EXEC && (!res_valid_r || res_ready)) begin
      we = change;
    end
  end

  assign q_pop = (st_r == S_IDLE) && q_valid &&
                 !(res_valid_r && !res_ready);
  assign res_valid = res_valid_r;
  assign res_data = res_r;

  // Sequencer: clear sweep, set read, execute and post the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + SET_W'(1);
          if (clr_r == SET_W'(SETS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            req_r <= q_head;
            st_r <= S_READ;
          end
        end
        S_READ: st_r <= S_EXEC;
        S_EXEC: begin
          if (!res_valid_r || res_ready) begin
            res_valid_r <= 1'b1;
            res_r <= res;
            clr_r <= '0;
            st_r <= (req_r.op == OP_CLEAR) ? S_CLR : S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/mesi_lru_cache_directory_core.sv @@
// Top level of the MESI/LRU cache directory. Instantiates the front part
// (accept and classify) and the back part (set lookup and update).
// Depends on mlcd_pkg, mlcd_front, mlcd_back and mlcd_ram.
//
// Usage: each input word carries an operation and a byte address; each
// produces exactly one result word on the out_ channel.
// Each access passes through the single row memory in turn: issue the set
// read, take the registered read data, then decide and write the set back;
// a new access is taken from the queue only once the last one is done.
// A clear operation, and reset, sweep every set of the memory back to its
// initial contents, one set per cycle; no access is executed meanwhile,
// but up to two words queue up at the input.
// A stalled receiver holds the result register; the front queue keeps
// accepting until it is full, then in_tready drops.
module mesi_lru_cache_directory_core import mlcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[3:0], address[35:4], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // outcome[1:0], hit_modified[2], way_used[6:3],
                                  // new_state[8:7], counts_read[9],
                                  // counts_write[10], zero fill
);

  logic      q_valid, q_pop;
  mlcd_req_t q_head;
  mlcd_res_t res;

  mlcd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata[35:0]), .q_valid(q_valid), .q_pop(q_pop),
    .q_head(q_head)
  );

  mlcd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_head(q_head), .res_valid(out_tvalid), .res_ready(out_tready),
    .res_data(res)
  );

  assign out_tdata = {5'd0, res};

endmodule

@@ design/mlcd_checker.sv @@
// Port-level checker for the cache directory, bound to the top level.
// Depends on mlcd_pkg.
module mlcd_checker import mlcd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result word is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Outcome code 3 is never produced.
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad outcome");

  // A result is never both a read and a write.
  a_rw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[9] && out_tdata[10]))
    else $error("read and write flags both set");

  // Modified-hit only comes with a hit.
  a_hitm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == OC_HIT)
    else $error("modified hit without hit");

endmodule

bind mesi_lru_cache_directory_core mlcd_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ sim/mesi_lru_cache_directory_checker.sv @@
// Checker for the MESI/LRU cache directory: watches both channels, keeps its
// own copy of the directory, predicts each result word and compares it.
// Depends on mlcd_pkg.
module mesi_lru_cache_directory_checker import mlcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          mismatch_count,
  output int          pending_count,
  output int          result_count
);

  // Shadow directory, indexed by set and way.
  logic [11:0] dir_tag   [SETS][WAYS];
  logic [1:0]  dir_state [SETS][WAYS];
  logic [3:0]  dir_age   [SETS][WAYS];

  mlcd_res_t pending_results[$];

  // Restore every set to its power-up contents.
  function automatic void wipe_directory();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        dir_tag[s][w]   = '0;
        dir_state[s][w] = ST_I;
        dir_age[s][w]   = 4'(w);
      end
    end
  endfunction

  // Make a way most recent; only younger-than-it ways move down.
  function automatic void promote_way(int s, int way);
    logic [3:0] old_age;
    old_age = dir_age[s][way];
    if (old_age != 4'(WAYS - 1)) begin
      for (int w = 0; w < WAYS; w++) begin
        if (dir_age[s][w] > old_age) dir_age[s][w]--;
      end
      dir_age[s][way] = 4'(WAYS - 1);
    end
  endfunction

  // Apply one access to the shadow directory and return its result word.
  function automatic mlcd_res_t apply_access(logic [3:0] op, logic [31:0] addr);
    mlcd_res_t r;
    logic [11:0] tag;
    int s, m, way;
    bit valid;
    tag = addr[31:20];
    s = int'(addr[19:6]) % SETS;
    r = '0;
    r.new_state = ST_I;
    m = WAYS;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (dir_tag[s][w] == tag) m = w;
    end
    case (op)
      OP_READ, OP_WRITE, OP_FETCH: begin
        r.counts_write = (op == OP_WRITE);
        r.counts_read  = (op != OP_WRITE);
        if (m < WAYS) begin
          way = m;
          valid = dir_state[s][way] != ST_I;
          r.outcome = valid ? OC_HIT : OC_MISS;
        end else begin
          way = 0;
          for (int w = WAYS - 1; w >= 0; w--) begin
            if (dir_age[s][w] == 0) way = w;
          end
          dir_tag[s][way] = tag;
          valid = 0;
          r.outcome = OC_MISS;
        end
        promote_way(s, way);
        if (op == OP_WRITE) dir_state[s][way] = ST_M;
        else if (!valid) dir_state[s][way] = ST_E;
        r.way_used  = 4'(way);
        r.new_state = dir_state[s][way];
      end
      OP_SN_INV, OP_SN_RD, OP_SN_WR, OP_SN_OWN: begin
        r.counts_write = (op == OP_SN_WR);
        r.counts_read  = (op == OP_SN_RD) || (op == OP_SN_OWN);
        if (m < WAYS) begin
          r.way_used = 4'(m);
          if (dir_state[s][m] != ST_I) begin
            r.outcome = OC_HIT;
            r.hit_modified = r.counts_read && dir_state[s][m] == ST_M;
            if (op == OP_SN_RD) begin
              dir_state[s][m] = ST_S;
            end else begin
              dir_state[s][m] = ST_I;
              promote_way(s, m);
            end
          end else begin
            r.outcome = OC_MISS;
          end
          r.new_state = dir_state[s][m];
        end else if (op == OP_SN_INV || op == OP_SN_WR) begin
          r.outcome = OC_MISS;
        end
      end
      OP_CLEAR: wipe_directory();
      default: ;
    endcase
    return r;
  endfunction

  initial wipe_directory();

  // Predict on each accepted input word, compare on each accepted result word.
  always @(posedge clk) begin
    mlcd_res_t got, want;
    if (!rst_n) begin
      mismatch_count <= 0;
      result_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_access(in_tdata[3:0], in_tdata[35:4]));
      end
      if (out_tvalid && out_tready) begin
        got = mlcd_res_t'(out_tdata[10:0]);
        result_count <= result_count + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: expected no result word, actual %h", $time, out_tdata);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (got !== want || out_tdata[15:11] !== '0) begin
            $display("%0t: expected %h (oc %0d hm %0d way %0d st %0d rd %0d wr %0d)",
                     $time, want, want.outcome, want.hit_modified, want.way_used,
                     want.new_state, want.counts_read, want.counts_write);
            $display("%0t: actual   %h (oc %0d hm %0d way %0d st %0d rd %0d wr %0d)",
                     $time, out_tdata, got.outcome, got.hit_modified, got.way_used,
                     got.new_state, got.counts_read, got.counts_write);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_count <= pending_results.size();
  end

endmodule

@@ sim/mesi_lru_cache_directory_core_tb.sv @@
// Testbench top for the MESI/LRU cache directory: drives accesses with
// random gaps and receiver stalls; the checker module judges every result.
// Depends on mlcd_pkg, mesi_lru_cache_directory_core and the checker.
module mesi_lru_cache_directory_core_tb import mlcd_pkg::*;;

  localparam int STALL_LIMIT = 3 * SETS + 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  int          mismatch_count, pending_count, result_count;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          quiet_cycles = 0;
  int          access_count = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  mesi_lru_cache_directory_core u_top (.*);

  mesi_lru_cache_directory_checker u_checker (.*);

  // Receiver stalls at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one word and hold it until it is taken.
  task automatic send_access(logic [3:0] op, logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {4'b0, addr, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    access_count++;
  endtask

  // Addresses built from a few tags and sets so lines collide and age out.
  function automatic logic [31:0] pick_address(int set_pool);
    logic [11:0] tag;
    logic [13:0] set_bits;
    tag = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(23));
    set_bits = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(set_pool));
    return {tag, set_bits, 6'($urandom)};
  endfunction

  function automatic logic [3:0] pick_op();
    int k;
    k = $urandom_range(99);
    if (k < 30) return OP_READ;
    if (k < 48) return OP_WRITE;
    if (k < 58) return OP_FETCH;
    if (k < 66) return OP_SN_INV;
    if (k < 76) return OP_SN_RD;
    if (k < 84) return OP_SN_WR;
    if (k < 93) return OP_SN_OWN;
    if (k < 98) return 4'($urandom_range(15, 9));
    return 4'd7;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: every operation, field extremes, ten new tags filling ways of one set.
    send_access(OP_SN_RD,  32'h0000_0000);
    send_access(OP_SN_OWN, 32'hFFFF_FFFF);
    send_access(OP_SN_INV, 32'h0000_0000);
    send_access(OP_READ,   32'h0000_0000);
    send_access(OP_READ,   32'h0000_0000);
    send_access(OP_WRITE,  32'hFFFF_FFFF);
    send_access(OP_SN_RD,  32'hFFFF_FFFF);
    send_access(OP_SN_OWN, 32'hFFFF_FFC0);
    send_access(OP_SN_WR,  32'hFFFF_FFC0);
    send_access(OP_FETCH,  32'hFFFF_FFC0);
    send_access(OP_WRITE,  32'h0000_0000);
    send_access(OP_SN_RD,  32'h0000_0000);
    send_access(4'd7,      32'h0000_0000);
    send_access(4'd15,     32'hAAAA_5555);
    for (int t = 1; t <= 10; t++) send_access(OP_READ, {12'(t), 20'h0_0040});
    send_access(OP_CLEAR,  32'h5555_AAAA);

    // Random phases with different idling mixes.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 34 : 0;
      for (int i = 0; i < 200; i++) begin
        if (phase == 2 && i == 150) send_access(OP_CLEAR, $urandom);
        else send_access(pick_op(), pick_address(phase == 1 ? 3 : 1));
      end
    end
    in_tvalid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d accesses over all operations, with clears; checked %0d results.",
             access_count, result_count);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
